[hw/rtl/lapf_pkg.sv]
`default_nettype none
package lapf_pkg;

	localparam int COL_W = 13;
	localparam int SUM_W = 13;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_CHANNEL_COUNT = 3'd2;
	localparam logic [2:0] REG_KERNEL_MODE   = 3'd3;
	localparam logic [2:0] REG_SCALE_Q8      = 3'd4;
	localparam logic [2:0] REG_DELTA_Q8      = 3'd5;

	typedef enum logic [1:0] {
		SLOT_MAIN   = 2'd0,
		SLOT_RIGHT  = 2'd1,
		SLOT_BOTTOM = 2'd2,
		SLOT_CORNER = 2'd3
	} slot_t;

	typedef logic [2:0][2:0][7:0] win_t;

	typedef struct packed {
		logic [13:0]        width;
		logic [15:0]        height;
		logic [2:0]         chans;
		logic               mode;
		logic signed [15:0] scale;
		logic signed [23:0] delta;
	} cfg_t;

	typedef struct packed {
		logic [7:0]       sample_px;
		logic [7:0]       upper_px;
		logic [7:0]       middle_px;
		logic [15:0]      row;
		logic [COL_W-1:0] col;
		logic [1:0]       ch;
		logic             emit;
		logic             last_col;
		logic             last_row;
		logic             last_ch;
		logic             top_edge;
		logic             left_edge;
	} item_t;

	function automatic logic signed [SUM_W-1:0] px(input win_t w, input logic [1:0] r,
			input logic [1:0] c);
		px = $signed({5'b0, w[r][c]});
	endfunction

	function automatic logic signed [SUM_W-1:0] kernel_sum(input win_t w, input logic mode,
			input logic [1:0] t, input logic [1:0] m, input logic [1:0] b,
			input logic [1:0] l, input logic [1:0] ce, input logic [1:0] rt);
		logic signed [SUM_W-1:0] nb;
		logic signed [SUM_W-1:0] mc;
		mc = px(w, m, ce);
		if (mode) begin
			nb = px(w, t, l) + px(w, t, rt) + px(w, b, l) + px(w, b, rt);
			kernel_sum = (nb <<< 1) - (mc <<< 3);
		end else begin
			nb = px(w, t, ce) + px(w, b, ce) + px(w, m, l) + px(w, m, rt);
			kernel_sum = nb - (mc <<< 2);
		end
	endfunction

endpackage
`default_nettype wire

[hw/rtl/lapf_fifo.sv]
`default_nettype none
module lapf_fifo (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	input  wire lapf_pkg::item_t               push_item,
	input  wire logic                          pop,
	output lapf_pkg::item_t                    head,
	output logic                               head_valid,
	output logic [lapf_pkg::QCNT_W-1:0]        count
);
	lapf_pkg::item_t slot_q [lapf_pkg::QUEUE_DEPTH];
	logic [lapf_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [lapf_pkg::QCNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_item;
	end

	assign head = slot_q[rd_q];
	assign head_valid = (count_q != '0);
	assign count = count_q;
endmodule
`default_nettype wire

[hw/rtl/lapf_front.sv]
`default_nettype none
module lapf_front #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_CHANNELS = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lapf_pkg::cfg_t                cfg,
	input  wire logic                          cfg_write,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [7:0]                    sample_value,
	input  wire logic [lapf_pkg::QCNT_W-1:0]   fifo_count,
	output logic                               push,
	output lapf_pkg::item_t                    push_item
);
	localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
	localparam int IDX_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	logic [15:0] row_q;
	logic [lapf_pkg::COL_W-1:0] col_q;
	logic [1:0] ch_q;
	logic [IDX_W-1:0] idx_q;

	logic [15:0] line_mem [LINE_DEPTH];
	logic [15:0] rd_s1;
	logic [IDX_W-1:0] idx_s1;
	lapf_pkg::item_t item_s1;
	logic valid_s1;

	logic acc, last_col, last_row, last_ch;

	assign in_ready = ((4'(fifo_count) + 4'(valid_s1)) < 4'(lapf_pkg::QUEUE_DEPTH));
	assign acc = in_valid && in_ready;
	assign last_col = (({1'b0, col_q} + 14'd1) == cfg.width);
	assign last_row = ((17'(row_q) + 17'd1) == 17'(cfg.height));
	assign last_ch = ((3'(ch_q) + 3'd1) == cfg.chans);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			ch_q <= '0;
			idx_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc;
			if (cfg_write) begin
				row_q <= '0;
				col_q <= '0;
				ch_q <= '0;
				idx_q <= '0;
			end else if (acc) begin
				if (last_ch) begin
					ch_q <= '0;
					if (last_col) begin
						col_q <= '0;
						idx_q <= '0;
						row_q <= last_row ? '0 : row_q + 16'd1;
					end else begin
						col_q <= col_q + 1'b1;
						idx_q <= idx_q + 1'b1;
					end
				end else begin
					ch_q <= ch_q + 2'd1;
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1 <= line_mem[idx_q];
			idx_s1 <= idx_q;
			item_s1.sample_px <= sample_value;
			item_s1.upper_px <= '0;
			item_s1.middle_px <= '0;
			item_s1.row <= row_q;
			item_s1.col <= col_q;
			item_s1.ch <= ch_q;
			item_s1.emit <= (row_q != '0) && (col_q != '0);
			item_s1.last_col <= last_col;
			item_s1.last_row <= last_row;
			item_s1.last_ch <= last_ch;
			item_s1.top_edge <= (row_q == 16'd1);
			item_s1.left_edge <= (col_q == lapf_pkg::COL_W'(1));
		end
		if (valid_s1) line_mem[idx_s1] <= {rd_s1[7:0], item_s1.sample_px};
	end

	always_comb begin
		push_item = item_s1;
		push_item.upper_px = rd_s1[15:8];
		push_item.middle_px = rd_s1[7:0];
	end
	assign push = valid_s1;
endmodule
`default_nettype wire

[hw/rtl/lapf_back.sv]
`default_nettype none
module lapf_back #(
	parameter int MAX_CHANNELS = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire lapf_pkg::cfg_t   cfg,
	input  wire lapf_pkg::item_t  head,
	input  wire logic             head_valid,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [7:0]            out_value,
	output logic [15:0]           out_row,
	output logic [10:0]           out_column,
	output logic [1:0]            out_channel,
	output logic                  run_last,
	output logic                  image_done
);
	localparam int LANE_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	lapf_pkg::win_t win_q [MAX_CHANNELS];
	logic [2:0] pend_q;
	logic [15:0] cur_row_q;
	logic [lapf_pkg::COL_W-1:0] cur_col_q;
	logic [1:0] cur_ch_q;
	logic cur_top_q, cur_left_q, cur_last_ch_q;

	logic en, busy, issue;
	logic [LANE_W-1:0] lane;
	lapf_pkg::win_t lane_win, new_win, use_win;
	lapf_pkg::slot_t slot;
	logic [2:0] pend_next, pend_head;
	logic top, left_e, last_ch;
	logic [15:0] row;
	logic [lapf_pkg::COL_W-1:0] col;
	logic [1:0] ch;
	logic [1:0] st, sm, sb, sl, sc, sr;

	logic valid_s1, valid_s2, valid_s3;
	logic signed [lapf_pkg::SUM_W-1:0] sum_s1;
	logic signed [28:0] prod_s2;
	logic [15:0] row_s1, row_s2;
	logic [lapf_pkg::COL_W-1:0] col_s1, col_s2, col_s3;
	logic [1:0] ch_s1, ch_s2;
	logic last_s1, last_s2, done_s1, done_s2;
	logic signed [29:0] acc_w;

	assign en = !valid_s3 || out_ready;
	assign busy = (pend_q != '0);
	assign pop = en && !busy && head_valid;
	assign issue = en && (busy || (pop && head.emit));

	assign lane = busy ? cur_ch_q[LANE_W-1:0] : head.ch[LANE_W-1:0];
	assign lane_win = win_q[lane];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			new_win[r][0] = lane_win[r][1];
			new_win[r][1] = lane_win[r][2];
		end
		new_win[0][2] = head.upper_px;
		new_win[1][2] = head.middle_px;
		new_win[2][2] = head.sample_px;
	end

	assign pend_head = {head.last_row && head.last_col, head.last_row, head.last_col};
	assign use_win = busy ? lane_win : new_win;
	assign top = busy ? cur_top_q : head.top_edge;
	assign left_e = busy ? cur_left_q : head.left_edge;
	assign last_ch = busy ? cur_last_ch_q : head.last_ch;
	assign row = busy ? cur_row_q : head.row;
	assign col = busy ? cur_col_q : head.col;
	assign ch = busy ? cur_ch_q : head.ch;
	assign pend_next = busy ? (pend_q & (pend_q - 3'd1)) : pend_head;

	always_comb begin
		if (!busy) slot = lapf_pkg::SLOT_MAIN;
		else if (pend_q[0]) slot = lapf_pkg::SLOT_RIGHT;
		else if (pend_q[1]) slot = lapf_pkg::SLOT_BOTTOM;
		else slot = lapf_pkg::SLOT_CORNER;
	end

	always_comb begin
		case (slot)
			lapf_pkg::SLOT_MAIN: begin
				st = top ? 2'd2 : 2'd0; sm = 2'd1; sb = 2'd2;
				sl = left_e ? 2'd2 : 2'd0; sc = 2'd1; sr = 2'd2;
			end
			lapf_pkg::SLOT_RIGHT: begin
				st = top ? 2'd2 : 2'd0; sm = 2'd1; sb = 2'd2;
				sl = 2'd1; sc = 2'd2; sr = 2'd1;
			end
			lapf_pkg::SLOT_BOTTOM: begin
				st = 2'd1; sm = 2'd2; sb = 2'd1;
				sl = left_e ? 2'd2 : 2'd0; sc = 2'd1; sr = 2'd2;
			end
			default: begin
				st = 2'd1; sm = 2'd2; sb = 2'd1;
				sl = 2'd1; sc = 2'd2; sr = 2'd1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) win_q[i] <= '0;
			pend_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (pop) begin
				win_q[lane] <= new_win;
				pend_q <= head.emit ? pend_head : 3'd0;
			end else if (en && busy) begin
				pend_q <= pend_next;
			end
			if (en) begin
				valid_s1 <= issue;
				valid_s2 <= valid_s1;
				valid_s3 <= valid_s2;
			end
		end
	end

	assign acc_w = 30'(prod_s2) + 30'(cfg.delta);

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_row_q <= head.row;
			cur_col_q <= head.col;
			cur_ch_q <= head.ch;
			cur_top_q <= head.top_edge;
			cur_left_q <= head.left_edge;
			cur_last_ch_q <= head.last_ch;
		end
		if (en) begin
			sum_s1 <= lapf_pkg::kernel_sum(use_win, cfg.mode, st, sm, sb, sl, sc, sr);
			row_s1 <= (slot == lapf_pkg::SLOT_MAIN || slot == lapf_pkg::SLOT_RIGHT)
				? row - 16'd1 : row;
			col_s1 <= (slot == lapf_pkg::SLOT_MAIN || slot == lapf_pkg::SLOT_BOTTOM)
				? col - 1'b1 : col;
			ch_s1 <= ch;
			last_s1 <= (pend_next == '0);
			done_s1 <= (slot == lapf_pkg::SLOT_CORNER) && last_ch;

			prod_s2 <= 29'(sum_s1) * 29'(cfg.scale);
			row_s2 <= row_s1;
			col_s2 <= col_s1;
			ch_s2 <= ch_s1;
			last_s2 <= last_s1;
			done_s2 <= done_s1;

			if (acc_w < 0) out_value <= 8'd0;
			else if (acc_w[29:16] != '0) out_value <= 8'd255;
			else out_value <= acc_w[15:8];
			out_row <= row_s2;
			col_s3 <= col_s2;
			out_channel <= ch_s2;
			run_last <= last_s2;
			image_done <= done_s2;
		end
	end

	assign out_column = col_s3[10:0];
	assign out_valid = valid_s3;
endmodule
`default_nettype wire

[hw/rtl/laplacian_filter_u8_core.sv]
`default_nettype none
// Channel   Handshake              Payload
// input     in_valid / in_ready    sample_value
// output    out_valid / out_ready  out_value, out_row, out_column, out_channel,
//                                  run_last, image_done
// config    cfg_write              cfg_index, cfg_data
//
// One sample a cycle accepted while the queue has room; the line store
// read-modify-write takes two stages. Each sample yields zero to four results,
// issued one a cycle by the back end unless the output stalls. Extra results at
// row ends briefly back the four-entry queue up to the input. Reset clears
// positions, queue and window; the line store keeps no reset. A configuration
// write to a defined register restarts the image at row zero.
module laplacian_filter_u8_core #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_CHANNELS = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_write,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [23:0]  cfg_data,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [7:0]   sample_value,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [7:0]        out_value,
	output logic [15:0]       out_row,
	output logic [10:0]       out_column,
	output logic [1:0]        out_channel,
	output logic              run_last,
	output logic              image_done
);
	logic [11:0] image_width_q;
	logic [15:0] image_height_q;
	logic [2:0] channel_count_q;
	logic kernel_mode_q;
	logic [15:0] scale_q8_q;
	logic [23:0] delta_q8_q;
	logic cfg_hit;

	lapf_pkg::cfg_t cfg;
	lapf_pkg::item_t push_item, head;
	logic push, pop, head_valid;
	logic [lapf_pkg::QCNT_W-1:0] fifo_count;

	always_comb begin
		case (cfg_index)
			lapf_pkg::REG_IMAGE_WIDTH, lapf_pkg::REG_IMAGE_HEIGHT,
			lapf_pkg::REG_CHANNEL_COUNT, lapf_pkg::REG_KERNEL_MODE,
			lapf_pkg::REG_SCALE_Q8, lapf_pkg::REG_DELTA_Q8: cfg_hit = cfg_write;
			default: cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= 12'd640;
			image_height_q <= 16'd480;
			channel_count_q <= 3'd1;
			kernel_mode_q <= 1'b0;
			scale_q8_q <= 16'd256;
			delta_q8_q <= 24'd0;
		end else if (cfg_write) begin
			case (cfg_index)
				lapf_pkg::REG_IMAGE_WIDTH: image_width_q <= cfg_data[11:0];
				lapf_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data[15:0];
				lapf_pkg::REG_CHANNEL_COUNT: channel_count_q <= cfg_data[2:0];
				lapf_pkg::REG_KERNEL_MODE: kernel_mode_q <= cfg_data[0];
				lapf_pkg::REG_SCALE_Q8: scale_q8_q <= cfg_data[15:0];
				lapf_pkg::REG_DELTA_Q8: delta_q8_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (image_width_q < 12'd2) cfg.width = 14'd2;
		else if ({2'b0, image_width_q} > 14'(MAX_WIDTH)) cfg.width = 14'(MAX_WIDTH);
		else cfg.width = {2'b0, image_width_q};
		cfg.height = (image_height_q < 16'd2) ? 16'd2 : image_height_q;
		if (channel_count_q == 3'd0) cfg.chans = 3'd1;
		else if (channel_count_q > 3'(MAX_CHANNELS)) cfg.chans = 3'(MAX_CHANNELS);
		else cfg.chans = channel_count_q;
		cfg.mode = kernel_mode_q;
		cfg.scale = $signed(scale_q8_q);
		cfg.delta = $signed(delta_q8_q);
	end

	lapf_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_CHANNELS(MAX_CHANNELS)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .cfg_write(cfg_hit),
		.in_valid(in_valid), .in_ready(in_ready), .sample_value(sample_value),
		.fifo_count(fifo_count), .push(push), .push_item(push_item)
	);

	lapf_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_item(push_item), .pop(pop),
		.head(head), .head_valid(head_valid), .count(fifo_count)
	);

	lapf_back #(.MAX_CHANNELS(MAX_CHANNELS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .head(head), .head_valid(head_valid),
		.pop(pop), .out_valid(out_valid), .out_ready(out_ready), .out_value(out_value),
		.out_row(out_row), .out_column(out_column), .out_channel(out_channel),
		.run_last(run_last), .image_done(image_done)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> fifo_count < lapf_pkg::QCNT_W'(lapf_pkg::QUEUE_DEPTH))
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue underflow");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_done |-> run_last)
		else $error("image end not last of its request");
endmodule
`default_nettype wire

[sim/tb_top.sv]
module tb_top;

	typedef struct {
		logic [7:0]  value;
		logic [15:0] row;
		logic [10:0] column;
		logic [1:0]  channel;
		logic        last;
		logic        done;
	} pixel_res_t;

	typedef struct {
		bit          is_reg;
		logic [2:0]  index;
		logic [23:0] data;
		bit          typed;
		logic [7:0]  typed_value;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  sample_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_value;
	logic [15:0] out_row;
	logic [10:0] out_column;
	logic [1:0]  out_channel;
	logic        run_last;
	logic        image_done;

	laplacian_filter_u8_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .sample_value(sample_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_value(out_value), .out_row(out_row), .out_column(out_column),
		.out_channel(out_channel), .run_last(run_last), .image_done(image_done)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [11:0] img_width = 12'd640;
	logic [15:0] img_height = 16'd480;
	logic [2:0]  chan_count = 3'd1;
	logic        diag_mode = 1'b0;
	logic [15:0] gain_q8 = 16'd256;
	logic [23:0] offset_q8 = 24'd0;
	logic [7:0]  upper_mem [0:8191];
	logic [7:0]  middle_mem [0:8191];
	logic [7:0]  win [0:35];
	int unsigned row_pos = 0, col_pos = 0, chan_pos = 0;

	pixel_res_t filtered_q[$];
	int   errors = 0;
	bit   calm = 1'b0;
	int   requests = 0;
	stim_row_t dir_rows[$];

	function automatic int pix(int r, int c, int k);
		return int'(win[(r * 3 + c) * 4 + k]);
	endfunction

	function automatic logic [7:0] laplace(int t, int m, int b, int l, int ce, int rt, int k);
		int s;
		longint acc;
		if (diag_mode)
			s = -8 * pix(m, ce, k) + 2 * (pix(t, l, k) + pix(t, rt, k) + pix(b, l, k)
				+ pix(b, rt, k));
		else
			s = -4 * pix(m, ce, k) + pix(t, ce, k) + pix(b, ce, k) + pix(m, l, k)
				+ pix(m, rt, k);
		acc = longint'(s) * longint'($signed(gain_q8)) + longint'($signed(offset_q8));
		if (acc < 0)
			return 8'd0;
		acc = acc >>> 8;
		return (acc > 255) ? 8'd255 : acc[7:0];
	endfunction

	function automatic pixel_res_t mk(logic [7:0] v, int r, int c, int k);
		pixel_res_t p;
		p.value = v; p.row = r[15:0]; p.column = c[10:0]; p.channel = k[1:0];
		p.last = 1'b0; p.done = 1'b0;
		return p;
	endfunction

	function automatic void apply_reg(logic [2:0] idx, logic [23:0] d);
		case (idx)
			lapf_pkg::REG_IMAGE_WIDTH:   img_width = d[11:0];
			lapf_pkg::REG_IMAGE_HEIGHT:  img_height = d[15:0];
			lapf_pkg::REG_CHANNEL_COUNT: chan_count = d[2:0];
			lapf_pkg::REG_KERNEL_MODE:   diag_mode = d[0];
			lapf_pkg::REG_SCALE_Q8:      gain_q8 = d[15:0];
			lapf_pkg::REG_DELTA_Q8:      offset_q8 = d;
			default:                     return;
		endcase
		row_pos = 0; col_pos = 0; chan_pos = 0;
	endfunction

	function automatic void predict_sample(logic [7:0] s, bit typed, logic [7:0] tv);
		int unsigned w, h, cn, r, c, k, idx, top, left;
		pixel_res_t res [0:3];
		int n;
		bit lc, lr;
		n = 0;
		w = (img_width < 2) ? 2 : ((img_width > 2048) ? 2048 : img_width);
		h = (img_height < 2) ? 2 : img_height;
		cn = (chan_count < 1) ? 1 : ((chan_count > 4) ? 4 : chan_count);
		r = row_pos; c = col_pos; k = chan_pos;
		if (k >= cn) k = 0;
		if (c >= w) c = 0;
		if (r >= h) r = 0;
		idx = (c * cn + k) % 8192;
		for (int i = 0; i < 3; i++) begin
			win[i * 12 + k] = win[i * 12 + 4 + k];
			win[i * 12 + 4 + k] = win[i * 12 + 8 + k];
		end
		win[8 + k] = upper_mem[idx];
		win[20 + k] = middle_mem[idx];
		win[32 + k] = s;
		upper_mem[idx] = middle_mem[idx];
		middle_mem[idx] = s;
		lc = (c + 1 == w);
		lr = (r + 1 == h);
		if (r >= 1 && c >= 1) begin
			top = (r == 1) ? 2 : 0;
			left = (c == 1) ? 2 : 0;
			res[n] = mk(laplace(top, 1, 2, left, 1, 2, k), r - 1, c - 1, k);
			n = n + 1;
			if (lc) begin
				res[n] = mk(laplace(top, 1, 2, 1, 2, 1, k), r - 1, c, k);
				n = n + 1;
			end
			if (lr) begin
				res[n] = mk(laplace(1, 2, 1, left, 1, 2, k), r, c - 1, k);
				n = n + 1;
			end
			if (lr && lc) begin
				res[n] = mk(laplace(1, 2, 1, 1, 2, 1, k), r, c, k);
				n = n + 1;
				res[n - 1].done = (k + 1 == cn);
			end
			res[n - 1].last = 1'b1;
			for (int i = 0; i < n; i++) begin
				if (typed)
					res[i].value = tv;
				filtered_q.push_back(res[i]);
			end
		end
		k++;
		if (k >= cn) begin
			k = 0;
			c++;
			if (c >= w) begin
				c = 0;
				r++;
				if (r >= h)
					r = 0;
			end
		end
		row_pos = r; col_pos = c; chan_pos = k;
	endfunction

	task automatic drain();
		while (filtered_q.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [23:0] d);
		drain();
		cfg_write = 1'b1; cfg_index = idx; cfg_data = d;
		apply_reg(idx, d);
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	task automatic send_sample(logic [7:0] s, bit typed, logic [7:0] tv);
		while (!calm && $urandom_range(0, 99) < 13)
			@(negedge clk);
		in_valid = 1'b1;
		sample_value = s;
		do
			@(posedge clk);
		while (!in_ready);
		predict_sample(s, typed, tv);
		requests++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic set_all(int w, int h, int ch, int md, logic [15:0] sc, logic [23:0] dl);
		write_reg(lapf_pkg::REG_IMAGE_WIDTH, 24'(w));
		write_reg(lapf_pkg::REG_IMAGE_HEIGHT, 24'(h));
		write_reg(lapf_pkg::REG_CHANNEL_COUNT, 24'(ch));
		write_reg(lapf_pkg::REG_KERNEL_MODE, 24'(md));
		write_reg(lapf_pkg::REG_SCALE_Q8, {8'd0, sc});
		write_reg(lapf_pkg::REG_DELTA_Q8, dl);
	endtask

	always @(negedge clk)
		out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 13);

	always @(posedge clk) begin
		pixel_res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (filtered_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result v=%0d r=%0d c=%0d k=%0d", out_value,
						out_row, out_column, out_channel);
			end else begin
				e = filtered_q.pop_front();
				if (out_value !== e.value || out_row !== e.row || out_column !== e.column
						|| out_channel !== e.channel || run_last !== e.last
						|| image_done !== e.done) begin
					errors++;
					if (errors <= 10)
						$display("mismatch exp v=%0d r=%0d c=%0d k=%0d l=%0b d=%0b",
							e.value, e.row, e.column, e.channel, e.last, e.done,
							" got v=%0d r=%0d c=%0d k=%0d l=%0b d=%0b",
							out_value, out_row, out_column, out_channel, run_last,
							image_done);
				end
			end
		end
	end

	initial begin
		#5000000;
		$display("FAIL laplacian_filter_u8_core");
		$finish;
	end

	initial begin
		int w, h, ch, n, phase;
		logic [15:0] sc;
		logic [23:0] dl;
		for (int i = 0; i < 8192; i++) begin
			upper_mem[i] = 8'd0;
			middle_mem[i] = 8'd0;
		end
		for (int i = 0; i < 36; i++)
			win[i] = 8'd0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// flat images give a zero sum, so the result is the offset alone
		dir_rows.push_back('{1'b1, lapf_pkg::REG_IMAGE_WIDTH, 24'd2, 1'b0, 8'd0});
		dir_rows.push_back('{1'b1, lapf_pkg::REG_IMAGE_HEIGHT, 24'd2, 1'b0, 8'd0});
		dir_rows.push_back('{1'b1, lapf_pkg::REG_CHANNEL_COUNT, 24'd1, 1'b0, 8'd0});
		dir_rows.push_back('{1'b1, lapf_pkg::REG_KERNEL_MODE, 24'd0, 1'b0, 8'd0});
		dir_rows.push_back('{1'b1, lapf_pkg::REG_SCALE_Q8, 24'd256, 1'b0, 8'd0});
		dir_rows.push_back('{1'b1, lapf_pkg::REG_DELTA_Q8, 24'd0, 1'b0, 8'd0});
		repeat (4) dir_rows.push_back('{1'b0, 3'd0, 24'd255, 1'b1, 8'd0});
		dir_rows.push_back('{1'b1, lapf_pkg::REG_DELTA_Q8, 24'h7FFFFF, 1'b0, 8'd0});
		repeat (4) dir_rows.push_back('{1'b0, 3'd0, 24'd0, 1'b1, 8'd255});
		dir_rows.push_back('{1'b1, lapf_pkg::REG_KERNEL_MODE, 24'd1, 1'b0, 8'd0});
		dir_rows.push_back('{1'b1, lapf_pkg::REG_SCALE_Q8, 24'h008000, 1'b0, 8'd0});
		dir_rows.push_back('{1'b1, lapf_pkg::REG_DELTA_Q8, 24'h800000, 1'b0, 8'd0});
		dir_rows.push_back('{1'b0, 3'd0, 24'd0, 1'b0, 8'd0});
		dir_rows.push_back('{1'b0, 3'd0, 24'd255, 1'b0, 8'd0});
		dir_rows.push_back('{1'b0, 3'd0, 24'd255, 1'b0, 8'd0});
		dir_rows.push_back('{1'b0, 3'd0, 24'd0, 1'b0, 8'd0});
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_reg)
				write_reg(dir_rows[i].index, dir_rows[i].data);
			else
				send_sample(dir_rows[i].data[7:0], dir_rows[i].typed, dir_rows[i].typed_value);
		end

		phase = 0;
		while (requests < 90 || phase < 3) begin
			w = $urandom_range(2, 6);
			h = $urandom_range(2, 4);
			ch = $urandom_range(1, 4);
			sc = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023) - 512);
			dl = 24'($urandom_range(0, 131071)) - 24'd65536;
			set_all(w, h, ch, $urandom_range(0, 1), sc, dl);
			calm = (phase == 2);
			n = w * h * ch;
			// occasionally cut the image short
			if ($urandom_range(0, 4) == 0)
				n = $urandom_range(1, n);
			for (int i = 0; i < n; i++) begin
				if (phase == 1 && i == n / 2)
					drain();
				send_sample(8'($urandom), 1'b0, 8'd0);
			end
			calm = 1'b0;
			phase++;
		end

		// widest row cut short, then tallest image cut short
		calm = 1'b1;
		set_all(2048, 2, 1, 1, 16'h7FFF, 24'd0);
		for (int i = 0; i < 24; i++)
			send_sample(8'($urandom), 1'b0, 8'd0);
		calm = 1'b0;
		set_all(3, 65535, 4, 0, 16'h0100, 24'h000040);
		for (int i = 0; i < 40; i++)
			send_sample(8'($urandom), 1'b0, 8'd0);

		drain();
		repeat (20) @(negedge clk);
		if (errors == 0 && filtered_q.size() == 0)
			$display("PASS laplacian_filter_u8_core");
		else
			$display("FAIL laplacian_filter_u8_core");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/lapf_pkg.sv
hw/rtl/lapf_fifo.sv
hw/rtl/lapf_front.sv
hw/rtl/lapf_back.sv
hw/rtl/laplacian_filter_u8_core.sv
sim/tb_top.sv
